[src/bsm_pkg.sv]
// ----------------------------------------------------------------------------
// bsm_pkg
// Shared widths, codes and types for the backing-store map table.
// ----------------------------------------------------------------------------
package bsm_pkg;

    // field widths
    localparam int SLOT_W  = 4;
    localparam int PID_W   = 6;
    localparam int VADDR_W = 32;
    localparam int FPAGE_W = 20;
    localparam int NPAGE_W = 9;
    localparam int OFFS_W  = 8;
    localparam int OWNER_W = 7;
    localparam int BASE_W  = 21;
    localparam int CMP_W   = 24;   // page compare width, holds base + count

    // defaults for top-level parameters
    localparam int DEF_TABLE_ENTRIES = 8;
    localparam int DEF_PAGE_BYTES    = 4096;

    localparam logic [NPAGE_W-1:0] MAX_PAGES  = 9'd256;
    localparam logic [OWNER_W-1:0] OWNER_NONE = 7'h7F;
    localparam logic [BASE_W-1:0]  BASE_NONE  = 21'h1F_FFFF;

    // command codes
    localparam logic [2:0] CMD_ALLOC   = 3'd0;
    localparam logic [2:0] CMD_RELEASE = 3'd1;
    localparam logic [2:0] CMD_LOOKUP  = 3'd2;
    localparam logic [2:0] CMD_MAP     = 3'd3;
    localparam logic [2:0] CMD_UNMAP   = 3'd4;

    typedef struct packed {
        logic               mapped;
        logic [OWNER_W-1:0] owner;
        logic [BASE_W-1:0]  base;
        logic [NPAGE_W-1:0] pages;
    } t_entry;

    localparam t_entry ENTRY_RESET = '{
        mapped: 1'b0,
        owner:  OWNER_NONE,
        base:   BASE_NONE,
        pages:  '0
    };

    typedef enum logic [1:0] {
        WR_RELEASE,
        WR_MAP,
        WR_UNMAP
    } t_wr_kind;

    typedef struct packed {
        logic               en;
        t_wr_kind           kind;
        logic [SLOT_W-1:0]  idx;
        logic [OWNER_W-1:0] owner;
        logic [BASE_W-1:0]  base;
        logic [NPAGE_W-1:0] pages;
    } t_tbl_wr;

    typedef struct packed {
        logic              hit;
        logic [OFFS_W-1:0] offset;
    } t_match;

endpackage

[src/bsm_table.sv]
// ----------------------------------------------------------------------------
// bsm_table
// Entry register file: one read port at the scan index, one write port.
// ----------------------------------------------------------------------------
module bsm_table #(
    parameter int ENTRIES = bsm_pkg::DEF_TABLE_ENTRIES,
    parameter int IDX_W   = 3
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_rd_idx,
    input  bsm_pkg::t_tbl_wr i_wr,
    output bsm_pkg::t_entry  o_entry
);

    bsm_pkg::t_entry  r_tbl [ENTRIES];
    logic [IDX_W-1:0] wr_idx;

    assign wr_idx  = i_wr.idx[IDX_W-1:0];
    assign o_entry = r_tbl[i_rd_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int e = 0; e < ENTRIES; e++) begin
                r_tbl[e] <= bsm_pkg::ENTRY_RESET;
            end
        end else if (i_wr.en) begin
            case (i_wr.kind)
                bsm_pkg::WR_RELEASE: begin
                    r_tbl[wr_idx] <= bsm_pkg::ENTRY_RESET;
                end
                bsm_pkg::WR_MAP: begin
                    r_tbl[wr_idx].mapped <= 1'b1;
                    r_tbl[wr_idx].owner  <= i_wr.owner;
                    r_tbl[wr_idx].base   <= i_wr.base;
                    r_tbl[wr_idx].pages  <= i_wr.pages;
                end
                bsm_pkg::WR_UNMAP: begin
                    r_tbl[wr_idx].mapped <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

[src/bsm_match.sv]
// ----------------------------------------------------------------------------
// bsm_match
// Shared compare unit: tests one entry against the current command.
// ----------------------------------------------------------------------------
module bsm_match (
    input  logic [2:0]                  i_cmd,
    input  bsm_pkg::t_entry             i_entry,
    input  logic [bsm_pkg::PID_W-1:0]   i_pid,
    input  logic [bsm_pkg::CMP_W-1:0]   i_page,
    input  logic [bsm_pkg::FPAGE_W-1:0] i_fpage,
    output bsm_pkg::t_match             o_match
);

    logic [bsm_pkg::CMP_W-1:0] lo;
    logic [bsm_pkg::CMP_W-1:0] hi;
    logic [bsm_pkg::CMP_W-1:0] diff;
    logic                      owner_eq;

    assign lo       = bsm_pkg::CMP_W'(i_entry.base);
    assign hi       = lo + bsm_pkg::CMP_W'(i_entry.pages);
    assign diff     = i_page - lo;
    assign owner_eq = (i_entry.owner == {1'b0, i_pid});

    always_comb begin
        o_match = '0;
        case (i_cmd)
            bsm_pkg::CMD_ALLOC: begin
                o_match.hit = !i_entry.mapped;
            end
            bsm_pkg::CMD_LOOKUP: begin
                o_match.hit    = i_entry.mapped && owner_eq &&
                                 (i_page >= lo) && (i_page < hi);
                o_match.offset = diff[bsm_pkg::OFFS_W-1:0];
            end
            bsm_pkg::CMD_UNMAP: begin
                // flag state is not part of the unmap match
                o_match.hit = owner_eq && (i_entry.base == {1'b0, i_fpage});
            end
            default: begin
            end
        endcase
    end

endmodule

[src/backing_store_map_table_core.sv]
// ----------------------------------------------------------------------------
// backing_store_map_table_core
// Table of backing-store mappings with allocate, release, lookup, map and
// unmap commands, walked one entry per cycle by a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel  i_valid / o_stall carries one command word (cmd, proc_id,
//   virt_addr, first_page, slot, page_count). Output channel o_valid / i_stall
//   returns one result word (status, found_slot, page_offset) per command.
//   Allocate, lookup and unmap scan the table from entry 0 through a single
//   compare unit, one entry per cycle, and stop at the first hit or after the
//   last entry; a miss answers an error. Release and map write one entry in
//   the write state and then answer.
//   One command is in flight at a time: o_stall is high from accept until the
//   result word is taken, and the sequencer passes through the idle state
//   before the next accept.
//   When the receiver stalls, the result word holds on the outputs and no
//   new command is taken.
//   Reset (synchronous, active low) empties the table: every
//   entry unmapped, no owner, no page, zero pages. The channels go idle.
//   PAGE_BYTES must be a power of two (the block does not check this); the page is virt_addr shifted right.
// ----------------------------------------------------------------------------
module backing_store_map_table_core #(
    parameter int TABLE_ENTRIES = bsm_pkg::DEF_TABLE_ENTRIES,
    parameter int PAGE_BYTES    = bsm_pkg::DEF_PAGE_BYTES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // command channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [2:0]                    i_cmd,
    input  logic [bsm_pkg::PID_W-1:0]     i_proc_id,
    input  logic [bsm_pkg::VADDR_W-1:0]   i_virt_addr,
    input  logic [bsm_pkg::FPAGE_W-1:0]   i_first_page,
    input  logic [bsm_pkg::SLOT_W-1:0]    i_slot,
    input  logic [bsm_pkg::NPAGE_W-1:0]   i_page_count,
    // result channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_status,
    output logic [bsm_pkg::SLOT_W-1:0]    o_found_slot,
    output logic [bsm_pkg::OFFS_W-1:0]    o_page_offset
);

    localparam int IDX_W    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int PG_SHIFT = $clog2(PAGE_BYTES);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_DONE
    } t_state;

    t_state                          r_state;
    logic [2:0]                      r_cmd;
    logic [bsm_pkg::PID_W-1:0]       r_pid;
    logic [bsm_pkg::CMP_W-1:0]       r_page;
    logic [bsm_pkg::FPAGE_W-1:0]     r_fpage;
    logic [bsm_pkg::SLOT_W-1:0]      r_slot;
    logic [bsm_pkg::NPAGE_W-1:0]     r_npages;
    logic [IDX_W-1:0]                r_idx;
    logic                            r_valid;
    logic                            r_status;
    logic [bsm_pkg::SLOT_W-1:0]      r_found;
    logic [bsm_pkg::OFFS_W-1:0]      r_offset;

    bsm_pkg::t_entry                 entry;
    bsm_pkg::t_match                 match;
    bsm_pkg::t_tbl_wr                tbl_wr;
    logic                            slot_ok;
    logic                            last_idx;
    logic                            wr_cmd;

    assign slot_ok  = ({1'b0, r_slot} < (bsm_pkg::SLOT_W + 1)'(TABLE_ENTRIES));
    assign last_idx = (r_idx == IDX_W'(TABLE_ENTRIES - 1));
    assign wr_cmd   = (r_cmd == bsm_pkg::CMD_RELEASE) || (r_cmd == bsm_pkg::CMD_MAP);

    bsm_table #(
        .ENTRIES (TABLE_ENTRIES),
        .IDX_W   (IDX_W)
    ) u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_idx (r_idx),
        .i_wr     (tbl_wr),
        .o_entry  (entry)
    );

    bsm_match u_match (
        .i_cmd   (r_cmd),
        .i_entry (entry),
        .i_pid   (r_pid),
        .i_page  (r_page),
        .i_fpage (r_fpage),
        .o_match (match)
    );

    // table write: release/map in the write state, flag clear on unmap hit
    always_comb begin
        tbl_wr       = '0;
        tbl_wr.owner = {1'b0, r_pid};
        tbl_wr.base  = {1'b0, r_fpage};
        tbl_wr.pages = r_npages;
        tbl_wr.idx   = r_slot;
        tbl_wr.kind  = bsm_pkg::WR_MAP;
        if (r_state == S_WRITE && slot_ok) begin
            case (r_cmd)
                bsm_pkg::CMD_RELEASE: begin
                    tbl_wr.en   = 1'b1;
                    tbl_wr.kind = bsm_pkg::WR_RELEASE;
                end
                bsm_pkg::CMD_MAP: begin
                    tbl_wr.en   = 1'b1;
                    tbl_wr.kind = bsm_pkg::WR_MAP;
                end
                default: begin
                end
            endcase
        end else if (r_state == S_SCAN && r_cmd == bsm_pkg::CMD_UNMAP && match.hit) begin
            tbl_wr.en   = 1'b1;
            tbl_wr.kind = bsm_pkg::WR_UNMAP;
            tbl_wr.idx  = bsm_pkg::SLOT_W'(r_idx);
        end
    end

    // sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_cmd    <= i_cmd;
                        r_pid    <= i_proc_id;
                        r_page   <= bsm_pkg::CMP_W'(i_virt_addr >> PG_SHIFT);
                        r_fpage  <= i_first_page;
                        r_slot   <= i_slot;
                        r_npages <= (i_page_count > bsm_pkg::MAX_PAGES) ?
                                    bsm_pkg::MAX_PAGES : i_page_count;
                        r_idx    <= '0;
                        if (i_cmd inside {bsm_pkg::CMD_ALLOC, bsm_pkg::CMD_LOOKUP,
                                          bsm_pkg::CMD_UNMAP}) begin
                            r_state <= S_SCAN;
                        end else begin
                            r_state <= S_WRITE;
                        end
                    end
                end
                S_SCAN: begin
                    if (match.hit) begin
                        r_status <= 1'b0;
                        r_found  <= bsm_pkg::SLOT_W'(r_idx);
                        r_offset <= match.offset;
                        r_valid  <= 1'b1;
                        r_state  <= S_DONE;
                    end else if (last_idx) begin
                        r_status <= 1'b1;
                        r_found  <= '0;
                        r_offset <= '0;
                        r_valid  <= 1'b1;
                        r_state  <= S_DONE;
                    end else begin
                        r_idx <= r_idx + IDX_W'(1);
                    end
                end
                S_WRITE: begin
                    // unknown codes also land here and answer an error
                    if (slot_ok && wr_cmd) begin
                        r_status <= 1'b0;
                        r_found  <= r_slot;
                    end else begin
                        r_status <= 1'b1;
                        r_found  <= '0;
                    end
                    r_offset <= '0;
                    r_valid  <= 1'b1;
                    r_state  <= S_DONE;
                end
                S_DONE: begin
                    if (!i_stall) begin
                        r_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                    r_valid <= 1'b0;
                end
            endcase
        end
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_found_slot  = r_found;
    assign o_page_offset = r_offset;

    // error answers carry no slot and no offset
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status) |-> (o_found_slot == '0 && o_page_offset == '0))
        else $error("error result with nonzero slot or offset");

    // a pending result keeps the command side closed
    a_busy_while_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("command accepted while result pending");

    // a successful answer names a slot inside the table
    a_slot_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_status) |->
        ({1'b0, o_found_slot} < (bsm_pkg::SLOT_W + 1)'(TABLE_ENTRIES)))
        else $error("success with slot outside table");

    // no result can appear in the cycle right after an accept
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> !o_valid)
        else $error("result too early after accept");

endmodule
